### hw/rtl/ttps_pkg.sv
// shared types, field codes and defaults for the transposition table probe store
`timescale 1ns / 1ps

package ttps_pkg;

   // default geometry
   localparam int INDEX_BITS_DEF = 16;
   localparam int LOCK_BITS_DEF  = 23;

   // tag layout below the lock: {depth, kind, age}
   localparam int DEPTH_BITS     = 7;
   localparam int KIND_BITS      = 2;
   localparam int AGE_BITS       = 8;
   localparam int TAG_EXTRA_BITS = DEPTH_BITS + KIND_BITS + AGE_BITS;

   localparam int FILL_BITS  = 17;
   localparam int CLASH_BITS = 32;
   localparam logic [FILL_BITS-1:0] FILL_MAX = '1;

   localparam logic signed [15:0] MATE_SHORTCUT = 16'sd9900;

   // request modes
   localparam logic [1:0] MODE_STORE        = 2'd0;
   localparam logic [1:0] MODE_PROBE_BOUNDS = 2'd1;

   // bound kinds
   localparam logic [KIND_BITS-1:0] KIND_UPPER = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_LOWER = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_EXACT = 2'd2;

   // probe status codes
   localparam logic [2:0] STATUS_STORE     = 3'd0;
   localparam logic [2:0] STATUS_MISS      = 3'd1;
   localparam logic [2:0] STATUS_HIT       = 3'd2;
   localparam logic [2:0] STATUS_ALPHA_CUT = 3'd3;
   localparam logic [2:0] STATUS_BETA_CUT  = 3'd4;
   localparam logic [2:0] STATUS_EXACT     = 3'd5;

   // store outcome codes
   localparam logic [2:0] OUTCOME_PROBE          = 3'd0;
   localparam logic [2:0] OUTCOME_FILLED         = 3'd1;
   localparam logic [2:0] OUTCOME_REFRESHED      = 3'd2;
   localparam logic [2:0] OUTCOME_KEPT_DEEPER    = 3'd3;
   localparam logic [2:0] OUTCOME_CLASH_REPLACED = 3'd4;
   localparam logic [2:0] OUTCOME_CLASH_KEPT     = 3'd5;

   typedef struct packed {
      logic [1:0]            mode;
      logic                  side;
      logic [15:0]           slot_key;
      logic [22:0]           check_lock;
      logic [DEPTH_BITS-1:0] search_depth;
      logic signed [15:0]    entry_score;
      logic [KIND_BITS-1:0]  bound_kind;
      logic [5:0]            src_square;
      logic [5:0]            dst_square;
      logic [7:0]            move_flags;
      logic signed [15:0]    alpha_bound;
      logic signed [15:0]    beta_bound;
   } req_word_type;

   typedef struct packed {
      logic [2:0]            probe_status;
      logic [2:0]            store_outcome;
      logic [5:0]            held_src;
      logic [5:0]            held_dst;
      logic [7:0]            held_flags;
      logic signed [15:0]    held_score;
      logic [FILL_BITS-1:0]  occupied_count;
      logic [CLASH_BITS-1:0] collision_count;
   } rsp_word_type;

   typedef struct packed {
      logic signed [15:0] score;
      logic [5:0]         src;
      logic [5:0]         dst;
      logic [7:0]         flags;
   } body_type;

   localparam int BODY_BITS = $bits(body_type);

   // what the decision logic asks the sequencer to do
   typedef struct packed {
      logic       wr_en;
      logic [2:0] probe_status;
      logic [2:0] store_outcome;
      logic       load_move;
      logic       load_score;
      logic       count_fill;
      logic       count_clash;
   } decision_type;

endpackage

### hw/rtl/transposition_table_probe_store.sv
// top level of the transposition table probe store: sequencer, counters and tables
`timescale 1ns / 1ps

// Direct-mapped search cache with one table per side, held in two synchronous
// memories: a tag memory (lock, depth, bound kind, age) and a body memory
// (score and move). Each request word passes through ST_IDLE and ST_RUN: the
// slot is read in the cycle the word is accepted, and in ST_RUN the tag and body
// are judged, written back if the store replaces the slot, and the response word
// is loaded into the output register. The tag memory's read-then-write of the
// addressed slot lets a new word in only after the last one leaves ST_RUN; a
// response still waiting on rsp_stall holds ST_RUN until the output register
// frees up. After reset a clearing pass writes every tag to empty, one slot per
// cycle over all 2 << INDEX_BITS slots (131072 by default), with req_stall high
// until it completes. The age register can be written at any time on the csr
// port but is meant to change only while no request is in flight.

module transposition_table_probe_store import ttps_pkg::*; #(
   parameter int INDEX_BITS = INDEX_BITS_DEF,
   parameter int LOCK_BITS  = LOCK_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // request word channel
   input  logic                req_valid,
   output logic                req_stall,
   input  req_word_type        req_word,
   // response word channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_word_type        rsp_word,
   // age register write
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [AGE_BITS-1:0] csr_data
);

   localparam int ADDR_BITS = INDEX_BITS + 1;
   localparam int DEPTH     = 2 << INDEX_BITS;
   localparam int TAG_BITS  = LOCK_BITS + TAG_EXTRA_BITS;

   // sequencer states
   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [ADDR_BITS-1:0]  clear_addr_ff, clear_addr_in;
   logic [AGE_BITS-1:0]   age_ff, age_in;

   req_word_type          req_hold_ff;
   rsp_word_type          rsp_word_ff, rsp_word_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [5:0]            held_src_ff, held_src_in;
   logic [5:0]            held_dst_ff, held_dst_in;
   logic [7:0]            held_flags_ff, held_flags_in;
   logic signed [15:0]    held_score_ff, held_score_in;
   logic [FILL_BITS-1:0]  fill_ff [2];
   logic [FILL_BITS-1:0]  fill_in [2];
   logic [CLASH_BITS-1:0] clash_ff, clash_in;

   logic                  accept;
   logic                  out_free;
   logic                  working;
   logic                  clearing;

   logic [ADDR_BITS-1:0]  rd_addr;
   logic [ADDR_BITS-1:0]  hold_addr;

   logic                  tag_wr_en;
   logic [ADDR_BITS-1:0]  tag_wr_addr;
   logic [TAG_BITS-1:0]   tag_wr_data;
   logic [TAG_BITS-1:0]   tag_new;
   logic [TAG_BITS-1:0]   tag_rd;
   logic                  body_wr_en;
   body_type              body_new;
   logic [BODY_BITS-1:0]  body_rd_bits;
   body_type              body_rd;

   decision_type          dec;

   // handshakes
   assign clearing  = (state_ff == ST_CLEAR);
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   // output register can take a word this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign working   = (state_ff == ST_RUN) && out_free;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // slot address: side selects the table half
   assign rd_addr   = {req_word.side, INDEX_BITS'(req_word.slot_key)};
   assign hold_addr = {req_hold_ff.side, INDEX_BITS'(req_hold_ff.slot_key)};

   // write-back image of the slot
   assign tag_new = {LOCK_BITS'(req_hold_ff.check_lock), req_hold_ff.search_depth,
                     req_hold_ff.bound_kind, age_ff};
   always_comb begin
      body_new       = '0;
      body_new.score = req_hold_ff.entry_score;
      body_new.src   = req_hold_ff.src_square;
      body_new.dst   = req_hold_ff.dst_square;
      body_new.flags = req_hold_ff.move_flags;
   end

   // clearing pass owns the tag write port until it finishes
   assign tag_wr_en   = clearing || (working && dec.wr_en);
   assign tag_wr_addr = clearing ? clear_addr_ff : hold_addr;
   assign tag_wr_data = clearing ? '0 : tag_new;
   assign body_wr_en  = working && dec.wr_en;
   assign body_rd     = body_rd_bits;

   ttps_ram #(
      .WIDTH (TAG_BITS),
      .DEPTH (DEPTH)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_wr_en),
      .wr_addr (tag_wr_addr),
      .wr_data (tag_wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (tag_rd)
   );

   ttps_ram #(
      .WIDTH (BODY_BITS),
      .DEPTH (DEPTH)
   ) u_body_ram (
      .clock   (clock),
      .wr_en   (body_wr_en),
      .wr_addr (hold_addr),
      .wr_data (body_new),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (body_rd_bits)
   );

   ttps_decide #(
      .LOCK_BITS (LOCK_BITS)
   ) u_decide (
      .req         (req_hold_ff),
      .tag         (tag_rd),
      .body        (body_rd),
      .current_age (age_ff),
      .dec         (dec)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // age register
   assign age_in = (csr_valid && csr_ready) ? csr_data : age_ff;

   // held move, counters and response word
   always_comb begin
      held_src_in   = held_src_ff;
      held_dst_in   = held_dst_ff;
      held_flags_in = held_flags_ff;
      held_score_in = held_score_ff;
      fill_in       = fill_ff;
      clash_in      = clash_ff;
      if (working) begin
         if (dec.load_move) begin
            held_src_in   = body_rd.src;
            held_dst_in   = body_rd.dst;
            held_flags_in = body_rd.flags;
         end
         if (dec.load_score) begin
            held_score_in = body_rd.score;
         end
         // both counters saturate
         if (dec.count_fill && fill_ff[req_hold_ff.side] != FILL_MAX) begin
            fill_in[req_hold_ff.side] = fill_ff[req_hold_ff.side] + 1'b1;
         end
         if (dec.count_clash && clash_ff != '1) begin
            clash_in = clash_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_word_in                 = '0;
      rsp_word_in.probe_status    = dec.probe_status;
      rsp_word_in.store_outcome   = dec.store_outcome;
      rsp_word_in.held_src        = held_src_in;
      rsp_word_in.held_dst        = held_dst_in;
      rsp_word_in.held_flags      = held_flags_in;
      rsp_word_in.held_score      = held_score_in;
      rsp_word_in.occupied_count  = fill_in[req_hold_ff.side];
      rsp_word_in.collision_count = clash_in;
   end

   // output valid: set on a finished word, dropped once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (working) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         age_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         held_src_ff   <= '0;
         held_dst_ff   <= '0;
         held_flags_ff <= '0;
         held_score_ff <= '0;
         fill_ff[0]    <= '0;
         fill_ff[1]    <= '0;
         clash_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         age_ff        <= age_in;
         rsp_valid_ff  <= rsp_valid_in;
         held_src_ff   <= held_src_in;
         held_dst_ff   <= held_dst_in;
         held_flags_ff <= held_flags_in;
         held_score_ff <= held_score_in;
         fill_ff[0]    <= fill_in[0];
         fill_ff[1]    <= fill_in[1];
         clash_ff      <= clash_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_hold_ff <= req_word;
      end
      if (working) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

### hw/rtl/ttps_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module ttps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/ttps_decide.sv
// store replacement and probe cutoff decision for one fetched slot
`timescale 1ns / 1ps

module ttps_decide import ttps_pkg::*; #(
   parameter int LOCK_BITS = LOCK_BITS_DEF
) (
   input  req_word_type                       req,
   input  logic [LOCK_BITS+TAG_EXTRA_BITS-1:0] tag,
   input  body_type                           body,
   input  logic [AGE_BITS-1:0]                current_age,
   output decision_type                       dec
);

   localparam int TAG_BITS = LOCK_BITS + TAG_EXTRA_BITS;

   logic [LOCK_BITS-1:0]  t_lock;
   logic [DEPTH_BITS-1:0] t_depth;
   logic [KIND_BITS-1:0]  t_kind;
   logic [AGE_BITS-1:0]   t_age;
   logic [LOCK_BITS-1:0]  req_lock;
   logic                  lock_hit;
   logic                  one_deeper;

   assign t_lock   = tag[TAG_BITS-1 -: LOCK_BITS];
   assign t_depth  = tag[TAG_EXTRA_BITS-1 -: DEPTH_BITS];
   assign t_kind   = tag[AGE_BITS+KIND_BITS-1 -: KIND_BITS];
   assign t_age    = tag[AGE_BITS-1:0];
   assign req_lock = LOCK_BITS'(req.check_lock);
   assign lock_hit = (t_lock == req_lock);
   // requested depth exactly one more than stored
   assign one_deeper = ({1'b0, req.search_depth} == ({1'b0, t_depth} + 8'd1));

   always_comb begin
      dec = '0;
      if (req.mode == MODE_STORE) begin
         if (t_lock == '0) begin
            dec.wr_en         = 1'b1;
            dec.count_fill    = 1'b1;
            dec.store_outcome = OUTCOME_FILLED;
         end else if (lock_hit) begin
            if (req.search_depth < t_depth) begin
               dec.store_outcome = OUTCOME_KEPT_DEEPER;
            end else begin
               dec.wr_en         = 1'b1;
               dec.store_outcome = OUTCOME_REFRESHED;
            end
         end else begin
            dec.count_clash = 1'b1;
            if (t_kind == KIND_EXACT && req.bound_kind != KIND_EXACT
                && t_age == current_age) begin
               dec.store_outcome = OUTCOME_CLASH_KEPT;
            end else begin
               dec.wr_en         = 1'b1;
               dec.store_outcome = OUTCOME_CLASH_REPLACED;
            end
         end
      end else if (!lock_hit) begin
         dec.probe_status = STATUS_MISS;
      end else begin
         dec.load_move = 1'b1;
         if (req.mode != MODE_PROBE_BOUNDS) begin
            // move-only probe
            dec.load_score   = 1'b1;
            dec.probe_status = STATUS_HIT;
         end else if (req.search_depth > t_depth) begin
            dec.probe_status = STATUS_HIT;
            if (one_deeper) begin
               if (t_kind == KIND_LOWER && body.score >= req.beta_bound) begin
                  dec.probe_status = STATUS_BETA_CUT;
               end else if (t_kind == KIND_UPPER && body.score <= req.alpha_bound) begin
                  dec.probe_status = STATUS_ALPHA_CUT;
               end
            end
         end else begin
            unique case (t_kind)
               KIND_LOWER: begin
                  dec.probe_status = (body.score >= req.beta_bound
                                      || body.score >= MATE_SHORTCUT)
                                     ? STATUS_BETA_CUT : STATUS_HIT;
               end
               KIND_UPPER: begin
                  dec.probe_status = (body.score <= req.alpha_bound)
                                     ? STATUS_ALPHA_CUT : STATUS_HIT;
               end
               KIND_EXACT: begin
                  dec.load_score   = 1'b1;
                  dec.probe_status = STATUS_EXACT;
               end
               default: begin
                  dec.probe_status = STATUS_HIT;
               end
            endcase
         end
      end
   end

endmodule

### verif/tb_transposition_table_probe_store.sv
// testbench for the transposition table probe store: directed table, then random words
`timescale 1ns / 1ps

module tb_transposition_table_probe_store;
   import ttps_pkg::*;

   // both tables side by side, indexed by {side, slot_key}
   localparam int TOTAL_SLOTS = 2 << INDEX_BITS_DEF;

   // codes the package leaves unnamed
   localparam logic [1:0]           MODE_PROBE_MOVE = 2'd2;
   localparam logic [1:0]           MODE_UNUSED     = 2'd3;
   localparam logic [KIND_BITS-1:0] KIND_UNUSED     = 2'd3;

   localparam int KEYS_PER_SIDE    = 8;
   localparam int LOCKS_PER_KEY    = 3;
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int DRAIN_CYCLES     = 8;
   // the idle stretch of the clearing pass alone stays well below this
   localparam int WATCHDOG_LIMIT   = 1000000;
   localparam int REPORT_LIMIT     = 10;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   req_word_type        req_word;
   logic                rsp_valid;
   logic                rsp_stall;
   rsp_word_type        rsp_word;
   logic                csr_valid;
   logic                csr_ready;
   logic [AGE_BITS-1:0] csr_data;

   transposition_table_probe_store uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------------
   // predictor state: own copy of both tables, held move, counters and age
   // ---------------------------------------------------------------------------
   bit [22:0]           tag_lock     [TOTAL_SLOTS];
   bit [DEPTH_BITS-1:0] tag_depth    [TOTAL_SLOTS];
   bit [KIND_BITS-1:0]  tag_kind     [TOTAL_SLOTS];
   bit [AGE_BITS-1:0]   tag_age      [TOTAL_SLOTS];
   bit signed [15:0]    body_score   [TOTAL_SLOTS];
   bit [5:0]            body_src     [TOTAL_SLOTS];
   bit [5:0]            body_dst     [TOTAL_SLOTS];
   bit [7:0]            body_flags   [TOTAL_SLOTS];
   // a body never written must never be read back by a zero lock probe
   bit                  body_written [TOTAL_SLOTS];

   bit [5:0]             held_src;
   bit [5:0]             held_dst;
   bit [7:0]             held_flags;
   bit signed [15:0]     held_score;
   bit [FILL_BITS-1:0]   fill_count [2];
   bit [CLASH_BITS-1:0]  clash_count;
   bit [AGE_BITS-1:0]    age_cfg;

   typedef struct {
      rsp_word_type word;
      int unsigned  item_no;
   } expected_rsp_type;

   expected_rsp_type pending_rsp_q [$];

   typedef struct {
      req_word_type w;
      bit           typed;
      logic [2:0]   status;
      logic [2:0]   outcome;
   } dir_row_type;

   dir_row_type dir_rows [$];

   logic [15:0] key_pool  [2][KEYS_PER_SIDE];
   logic [22:0] lock_pool [2][KEYS_PER_SIDE][LOCKS_PER_KEY];

   int unsigned error_count;
   int unsigned sent_count;
   int unsigned idle_cycles;
   bit          idle_on;
   bit          long_hold_req;

   function automatic void write_slot(input int unsigned at, input req_word_type w);
      tag_lock[at]     = w.check_lock;
      tag_depth[at]    = w.search_depth;
      tag_kind[at]     = w.bound_kind;
      tag_age[at]      = age_cfg;
      body_score[at]   = w.entry_score;
      body_src[at]     = w.src_square;
      body_dst[at]     = w.dst_square;
      body_flags[at]   = w.move_flags;
      body_written[at] = 1'b1;
   endfunction

   // apply one request word to the predictor state and return the response word
   function automatic rsp_word_type predict_probe_store(input req_word_type w);
      rsp_word_type r;
      int unsigned  at;
      at = {w.side, w.slot_key};
      r = '0;
      r.probe_status  = STATUS_STORE;
      r.store_outcome = OUTCOME_PROBE;
      if (w.mode == MODE_STORE) begin
         if (tag_lock[at] == '0) begin
            // empty slot, counted even when the new lock is zero
            write_slot(at, w);
            if (fill_count[w.side] != FILL_MAX)
               fill_count[w.side]++;
            r.store_outcome = OUTCOME_FILLED;
         end else if (tag_lock[at] == w.check_lock) begin
            if (w.search_depth < tag_depth[at]) begin
               r.store_outcome = OUTCOME_KEPT_DEEPER;
            end else begin
               write_slot(at, w);
               r.store_outcome = OUTCOME_REFRESHED;
            end
         end else begin
            if (clash_count != '1)
               clash_count++;
            // a current exact entry survives a bound entry
            if (tag_kind[at] == KIND_EXACT && w.bound_kind != KIND_EXACT
                && tag_age[at] == age_cfg) begin
               r.store_outcome = OUTCOME_CLASH_KEPT;
            end else begin
               write_slot(at, w);
               r.store_outcome = OUTCOME_CLASH_REPLACED;
            end
         end
      end else if (tag_lock[at] != w.check_lock) begin
         r.probe_status = STATUS_MISS;
      end else begin
         held_src   = body_src[at];
         held_dst   = body_dst[at];
         held_flags = body_flags[at];
         if (w.mode != MODE_PROBE_BOUNDS) begin
            // move-only probe, unused mode included
            held_score     = body_score[at];
            r.probe_status = STATUS_HIT;
         end else if (w.search_depth > tag_depth[at]) begin
            r.probe_status = STATUS_HIT;
            // one ply short still allows the plain bound cutoffs
            if (w.search_depth == tag_depth[at] + 1) begin
               if (tag_kind[at] == KIND_LOWER && body_score[at] >= w.beta_bound)
                  r.probe_status = STATUS_BETA_CUT;
               else if (tag_kind[at] == KIND_UPPER && body_score[at] <= w.alpha_bound)
                  r.probe_status = STATUS_ALPHA_CUT;
            end
         end else if (tag_kind[at] == KIND_LOWER) begin
            r.probe_status = (body_score[at] >= w.beta_bound || body_score[at] >= MATE_SHORTCUT)
                             ? STATUS_BETA_CUT : STATUS_HIT;
         end else if (tag_kind[at] == KIND_UPPER) begin
            r.probe_status = (body_score[at] <= w.alpha_bound) ? STATUS_ALPHA_CUT : STATUS_HIT;
         end else if (tag_kind[at] == KIND_EXACT) begin
            held_score     = body_score[at];
            r.probe_status = STATUS_EXACT;
         end else begin
            r.probe_status = STATUS_HIT;
         end
      end
      r.held_src        = held_src;
      r.held_dst        = held_dst;
      r.held_flags      = held_flags;
      r.held_score      = held_score;
      r.occupied_count  = fill_count[w.side];
      r.collision_count = clash_count;
      return r;
   endfunction

   function automatic void add_row(input logic [1:0] mode, input logic side,
                                   input logic [15:0] key, input logic [22:0] lock,
                                   input logic [6:0] depth, input int score,
                                   input logic [1:0] kind, input logic [5:0] src,
                                   input logic [5:0] dst, input logic [7:0] flags,
                                   input int alpha, input int beta, input bit typed,
                                   input logic [2:0] status, input logic [2:0] outcome);
      dir_row_type row;
      row.w              = '0;
      row.w.mode         = mode;
      row.w.side         = side;
      row.w.slot_key     = key;
      row.w.check_lock   = lock;
      row.w.search_depth = depth;
      row.w.entry_score  = 16'(score);
      row.w.bound_kind   = kind;
      row.w.src_square   = src;
      row.w.dst_square   = dst;
      row.w.move_flags   = flags;
      row.w.alpha_bound  = 16'(alpha);
      row.w.beta_bound   = 16'(beta);
      row.typed          = typed;
      row.status         = status;
      row.outcome        = outcome;
      dir_rows.push_back(row);
   endfunction

   // mostly small scores near zero, some near the mate shortcut, some full range
   function automatic logic signed [15:0] pick_score();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel == 0)
         return 16'($urandom);
      if (sel == 1)
         return 16'(int'(MATE_SHORTCUT) + int'($urandom_range(0, 200)) - 100);
      return 16'(int'($urandom_range(0, 400)) - 200);
   endfunction

   // random word aimed at a small set of slots and locks so hits and clashes are common
   function automatic req_word_type random_request();
      req_word_type w;
      int unsigned  pick;
      int unsigned  ki;
      w      = '0;
      w.side = 1'($urandom_range(0, 1));
      ki     = $urandom_range(0, KEYS_PER_SIDE - 1);
      pick   = $urandom_range(0, 99);
      if (pick < 40)
         w.mode = MODE_STORE;
      else if (pick < 85)
         w.mode = MODE_PROBE_BOUNDS;
      else if (pick < 95)
         w.mode = MODE_PROBE_MOVE;
      else
         w.mode = MODE_UNUSED;
      w.slot_key = ($urandom_range(0, 9) == 0) ? 16'($urandom) : key_pool[w.side][ki];
      pick = $urandom_range(0, 99);
      if (pick < 3)
         w.check_lock = '0;
      else if (pick < 8)
         w.check_lock = 23'($urandom);
      else
         w.check_lock = lock_pool[w.side][ki][$urandom_range(0, LOCKS_PER_KEY - 1)];
      w.search_depth = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 12));
      w.entry_score  = pick_score();
      w.bound_kind   = ($urandom_range(0, 15) == 0) ? KIND_UNUSED : 2'($urandom_range(0, 2));
      w.src_square   = 6'($urandom);
      w.dst_square   = 6'($urandom);
      w.move_flags   = 8'($urandom);
      w.alpha_bound  = pick_score();
      w.beta_bound   = pick_score();
      return w;
   endfunction

   // ---------------------------------------------------------------------------
   // request side: words change at the falling edge, handshake seen at the rising edge
   // ---------------------------------------------------------------------------
   task automatic send_request(input req_word_type w, input bit typed,
                               input logic [2:0] typed_status, input logic [2:0] typed_outcome);
      expected_rsp_type exp_rsp;
      int unsigned      gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      // a zero lock probe may only land on a slot whose body has been written
      if (w.mode != MODE_STORE && w.check_lock == '0 && !body_written[{w.side, w.slot_key}])
         w.check_lock = 23'd1;
      req_word  <= w;
      req_valid <= 1'b1;
      do
         @(posedge clock);
      while (!(req_valid && !req_stall));
      sent_count++;
      exp_rsp.word    = predict_probe_store(w);
      exp_rsp.item_no = sent_count;
      // table rows with a typed answer override the predicted codes
      if (typed) begin
         exp_rsp.word.probe_status  = typed_status;
         exp_rsp.word.store_outcome = typed_outcome;
      end
      pending_rsp_q.push_back(exp_rsp);
   endtask

   // stop offering words and let every outstanding response come back
   task automatic drain_requests();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_age(input logic [AGE_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      age_cfg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int count, input int pause_at, input int hold_at);
      for (int i = 0; i < count; i++) begin
         // sender waits for an empty pipeline once
         if (i == pause_at)
            drain_requests();
         // receiver holds off while words keep coming, so the block backs up
         if (i == hold_at)
            long_hold_req = 1'b1;
         send_request(random_request(), 1'b0, STATUS_STORE, OUTCOME_PROBE);
      end
   endtask

   // ---------------------------------------------------------------------------
   // response side stall: short random bursts, calm stretches, one long hold
   // ---------------------------------------------------------------------------
   initial begin : rsp_stall_gen
      int unsigned burst;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold_req = 1'b0;
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 13);
            rsp_stall <= 1'b1;
            repeat (burst - 1) @(negedge clock);
         end else if (idle_on && $urandom_range(0, 19) == 0) begin
            // calm stretch with no stall at all
            rsp_stall <= 1'b0;
            repeat ($urandom_range(20, 60)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // response check: every accepted word against the oldest expectation
   // ---------------------------------------------------------------------------
   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got, input int unsigned item_no);
      if (got !== want) begin
         error_count++;
         if (error_count <= REPORT_LIMIT)
            $display("mismatch on word %0d, %s: expected %0h, got %0h",
                     item_no, name, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      expected_rsp_type head;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp_q.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("response word with nothing expected: %0h", rsp_word);
         end else begin
            head = pending_rsp_q.pop_front();
            compare_field("probe_status", head.word.probe_status, rsp_word.probe_status,
                          head.item_no);
            compare_field("store_outcome", head.word.store_outcome, rsp_word.store_outcome,
                          head.item_no);
            compare_field("held_src", head.word.held_src, rsp_word.held_src, head.item_no);
            compare_field("held_dst", head.word.held_dst, rsp_word.held_dst, head.item_no);
            compare_field("held_flags", head.word.held_flags, rsp_word.held_flags,
                          head.item_no);
            compare_field("held_score", head.word.held_score, rsp_word.held_score,
                          head.item_no);
            compare_field("occupied_count", head.word.occupied_count,
                          rsp_word.occupied_count, head.item_no);
            compare_field("collision_count", head.word.collision_count,
                          rsp_word.collision_count, head.item_no);
         end
      end
   end

   // watchdog: ends the run after too long with no word moving on any channel
   always @(posedge clock) begin : watchdog
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_transposition_table_probe_store: FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin : main_seq
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_word      = '0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      error_count   = 0;
      sent_count    = 0;
      idle_cycles   = 0;
      idle_on       = 1'b1;
      long_hold_req = 1'b0;
      age_cfg       = '0;

      foreach (key_pool[s, k])
         key_pool[s][k] = 16'($urandom);
      key_pool[0][0]                 = '0;
      key_pool[1][KEYS_PER_SIDE - 1] = '1;
      foreach (lock_pool[s, k, l])
         lock_pool[s][k][l] = 23'($urandom_range(1, 23'h7FFFFF));

      // side 0 slot 0: miss, fill, cutoffs, depth rules, clash handling, all modes
      add_row(MODE_PROBE_BOUNDS, 0, 16'h0000, 23'd1, 0, 0, KIND_UPPER, 0, 0, 0, 0, 0,
              1, STATUS_MISS, OUTCOME_PROBE);
      add_row(MODE_STORE, 0, 16'h0000, 23'd1, 10, 100, KIND_LOWER, 63, 0, 8'hFF, 0, 0,
              1, STATUS_STORE, OUTCOME_FILLED);
      add_row(MODE_PROBE_BOUNDS, 0, 16'h0000, 23'd1, 10, 0, KIND_UPPER, 0, 0, 0, 0, 100,
              1, STATUS_BETA_CUT, OUTCOME_PROBE);
      add_row(MODE_PROBE_BOUNDS, 0, 16'h0000, 23'd1, 10, 0, KIND_UPPER, 0, 0, 0, 0, 101,
              0, STATUS_HIT, OUTCOME_PROBE);
      add_row(MODE_STORE, 0, 16'h0000, 23'd1, 5, 7, KIND_EXACT, 5, 5, 5, 0, 0,
              1, STATUS_STORE, OUTCOME_KEPT_DEEPER);
      add_row(MODE_STORE, 0, 16'h0000, 23'd1, 10, 9950, KIND_LOWER, 1, 2, 3, 0, 0,
              1, STATUS_STORE, OUTCOME_REFRESHED);
      // mate shortcut beats a beta that is out of reach
      add_row(MODE_PROBE_BOUNDS, 0, 16'h0000, 23'd1, 3, 0, KIND_UPPER, 0, 0, 0, 0, 32767,
              0, STATUS_BETA_CUT, OUTCOME_PROBE);
      // one ply short, then two plies short
      add_row(MODE_PROBE_BOUNDS, 0, 16'h0000, 23'd1, 11, 0, KIND_UPPER, 0, 0, 0, 0, -32768,
              0, STATUS_BETA_CUT, OUTCOME_PROBE);
      add_row(MODE_PROBE_BOUNDS, 0, 16'h0000, 23'd1, 12, 0, KIND_UPPER, 0, 0, 0, 0, -32768,
              0, STATUS_HIT, OUTCOME_PROBE);
      add_row(MODE_STORE, 0, 16'h0000, 23'd2, 127, -32768, KIND_EXACT, 0, 63, 0, 0, 0,
              1, STATUS_STORE, OUTCOME_CLASH_REPLACED);
      add_row(MODE_STORE, 0, 16'h0000, 23'd3, 0, 55, KIND_UPPER, 9, 9, 9, 0, 0,
              1, STATUS_STORE, OUTCOME_CLASH_KEPT);
      add_row(MODE_PROBE_BOUNDS, 0, 16'h0000, 23'd2, 127, 0, KIND_UPPER, 0, 0, 0, 0, 0,
              1, STATUS_EXACT, OUTCOME_PROBE);
      add_row(MODE_PROBE_MOVE, 0, 16'h0000, 23'd2, 0, 0, KIND_UPPER, 0, 0, 0, 0, 0,
              1, STATUS_HIT, OUTCOME_PROBE);
      add_row(MODE_UNUSED, 0, 16'h0000, 23'd2, 0, 0, KIND_UPPER, 0, 0, 0, 0, 0,
              1, STATUS_HIT, OUTCOME_PROBE);
      // side 1 top slot with the widest lock: upper bound cutoffs
      add_row(MODE_STORE, 1, 16'hFFFF, 23'h7FFFFF, 0, -500, KIND_UPPER, 42, 21, 8'hA5, 0, 0,
              1, STATUS_STORE, OUTCOME_FILLED);
      add_row(MODE_PROBE_BOUNDS, 1, 16'hFFFF, 23'h7FFFFF, 0, 0, KIND_UPPER, 0, 0, 0, -500, 0,
              1, STATUS_ALPHA_CUT, OUTCOME_PROBE);
      add_row(MODE_PROBE_BOUNDS, 1, 16'hFFFF, 23'h7FFFFF, 1, 0, KIND_UPPER, 0, 0, 0, 32767, 0,
              0, STATUS_ALPHA_CUT, OUTCOME_PROBE);
      add_row(MODE_PROBE_BOUNDS, 1, 16'hFFFF, 23'h7FFFFF, 0, 0, KIND_UPPER, 0, 0, 0, -501, 0,
              0, STATUS_HIT, OUTCOME_PROBE);
      // zero lock store on an empty slot, the unused bound kind, and a zero lock probe
      add_row(MODE_STORE, 1, 16'h0001, 23'd0, 50, 32767, KIND_UNUSED, 7, 8, 8'h5A, 0, 0,
              1, STATUS_STORE, OUTCOME_FILLED);
      add_row(MODE_PROBE_BOUNDS, 1, 16'h0001, 23'd0, 50, 0, KIND_UPPER, 0, 0, 0, 32767, -32768,
              0, STATUS_HIT, OUTCOME_PROBE);
      add_row(MODE_STORE, 1, 16'h0001, 23'd0, 1, 1, KIND_LOWER, 1, 1, 1, 0, 0,
              1, STATUS_STORE, OUTCOME_FILLED);
      // clash replacement with a zero lock empties the slot but keeps the count
      add_row(MODE_STORE, 1, 16'h0002, 23'd9, 4, -77, KIND_LOWER, 3, 4, 5, 0, 0,
              1, STATUS_STORE, OUTCOME_FILLED);
      add_row(MODE_STORE, 1, 16'h0002, 23'd0, 4, -88, KIND_UPPER, 6, 7, 8, 0, 0,
              1, STATUS_STORE, OUTCOME_CLASH_REPLACED);
      add_row(MODE_PROBE_BOUNDS, 1, 16'h0002, 23'd0, 4, 0, KIND_UPPER, 0, 0, 0, 32767, 0,
              0, STATUS_ALPHA_CUT, OUTCOME_PROBE);
      add_row(MODE_STORE, 1, 16'h0002, 23'd5, 2, 12, KIND_EXACT, 10, 11, 12, 0, 0,
              1, STATUS_STORE, OUTCOME_FILLED);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // age 0 for the directed table; requests wait out the clearing pass
      write_age(8'd0);
      foreach (dir_rows[i])
         send_request(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].status, dir_rows[i].outcome);
      drain_requests();

      // top age, with one sender pause
      write_age(8'd255);
      run_random(450, 200, -1);
      drain_requests();

      // back to age 0 so old exact entries lose on a clash, with one long receiver hold
      write_age(8'd0);
      run_random(450, -1, 100);
      drain_requests();

      write_age(8'($urandom_range(1, 254)));
      run_random(350, -1, -1);
      drain_requests();

      // last stretch back to back, no idling on either side
      write_age(8'd128);
      idle_on = 1'b0;
      run_random(300, -1, -1);
      drain_requests();

      if (error_count == 0 && pending_rsp_q.size() == 0)
         $display("tb_transposition_table_probe_store: PASS");
      else
         $display("tb_transposition_table_probe_store: FAIL");
      $finish;
   end

endmodule
